// File: rtl/core/bfa_pkg.sv
// Shared types, constants and register codes for the balance feedback block.
// No dependencies; compile first.
package bfa_pkg;

	localparam int BFA_MAX_DUTY    = 1024;
	localparam int BFA_ACCUM_BITS  = 24;
	localparam int CFG_IDX_BITS    = 3;
	localparam int CFG_DATA_BITS   = 16;
	localparam int DUTY_FIELD_BITS = 11;
	localparam int WHEELS          = 3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_GAIN_ANGLE  = 3'd0,
		REG_GAIN_RATE   = 3'd1,
		REG_GAIN_SUM    = 3'd2,
		REG_START_ANGLE = 3'd3,
		REG_LIMIT_ANGLE = 3'd4,
		REG_LIMIT_DRIVE = 3'd5,
		REG_MIX_X       = 3'd6,
		REG_MIX_Y       = 3'd7
	} cfg_reg_t;

	// event codes reported with each result
	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_ARM    = 2'd1;
	localparam logic [1:0] EV_DISARM = 2'd2;
	localparam logic [1:0] EV_BOTH   = 2'd3;

	// wheel order in the wheel command array
	localparam int WHEEL_C = 0;
	localparam int WHEEL_L = 1;
	localparam int WHEEL_R = 2;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] tilt_x;
		logic signed [15:0] tilt_y;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
	} in_item_t;

	typedef struct packed {
		logic [DUTY_FIELD_BITS-1:0] duty_c;
		logic                       forward_c;
		logic [DUTY_FIELD_BITS-1:0] duty_l;
		logic                       forward_l;
		logic [DUTY_FIELD_BITS-1:0] duty_r;
		logic                       forward_r;
		logic                       brake_free;
		logic                       armed;
		logic [1:0]                 event_res;
	} out_item_t;

	typedef struct packed {
		logic [DUTY_FIELD_BITS-1:0] duty;
		logic                       forward;
	} wheel_cmd_t;

	// step strobes for one axis lane
	typedef struct packed {
		logic mul;
		logic sum;
		logic sat;
		logic acc;
		logic commit;
		logic clear;
	} lane_ctl_t;

	// step strobes for the wheel merge stage
	typedef struct packed {
		logic mix;
		logic clamp;
		logic scale;
		logic duty;
		logic single;
	} merge_ctl_t;

endpackage

// File: rtl/core/bfa_stream_if.sv
// Valid/ready stream channel carrying one request or result payload.
// Payload type is supplied per instance, usually a struct from bfa_pkg.
interface bfa_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/bfa_lane.sv
// One axis lane: feedback sum, saturation, accumulator and mix product.
// Depends on bfa_pkg (lane_ctl_t).
module bfa_lane #(
	parameter int ACCUM_BITS = bfa_pkg::BFA_ACCUM_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bfa_pkg::lane_ctl_t           ctl,
	input  logic signed [15:0]           tilt,
	input  logic signed [15:0]           rate,
	input  logic signed [15:0]           gain_angle,
	input  logic signed [15:0]           gain_rate,
	input  logic signed [15:0]           gain_sum,
	input  logic signed [15:0]           mix,
	output logic signed [ACCUM_BITS-1:0] axis_out,
	output logic signed [ACCUM_BITS+15:0] mix_prod
);
	localparam int SW = ((ACCUM_BITS + 8 > 28) ? ACCUM_BITS + 8 : 28) + 1;

	logic signed [31:0]            pa_s1, pr_s1;
	logic signed [ACCUM_BITS+15:0] ps_s1;
	logic signed [27:0]            ang_s2;
	logic signed [ACCUM_BITS+7:0]  sp_s2;
	logic signed [ACCUM_BITS-1:0]  out_s3;
	logic signed [ACCUM_BITS+15:0] mixp_s4;
	logic signed [ACCUM_BITS-1:0]  acc_q;

	logic signed [32:0]           angsum;
	logic signed [SW-1:0]         tot;
	logic signed [ACCUM_BITS:0]   accsum;
	logic [SW-ACCUM_BITS:0]       tot_hi;
	logic [1:0]                   acc_hi;
	logic signed [ACCUM_BITS-1:0] tot_sat, acc_sat;

	assign angsum = 33'(pa_s1) + 33'(pr_s1);
	assign tot    = SW'(ang_s2) + SW'(sp_s2);
	assign accsum = (ACCUM_BITS+1)'(acc_q) + (ACCUM_BITS+1)'(out_s3);
	assign tot_hi = tot[SW-1:ACCUM_BITS-1];
	assign acc_hi = accsum[ACCUM_BITS:ACCUM_BITS-1];

	// clip to the signed accumulator range
	always_comb begin
		if ((&tot_hi) || !(|tot_hi)) begin
			tot_sat = tot[ACCUM_BITS-1:0];
		end else begin
			tot_sat = {tot[SW-1], {(ACCUM_BITS-1){~tot[SW-1]}}};
		end
		if (acc_hi[1] == acc_hi[0]) begin
			acc_sat = accsum[ACCUM_BITS-1:0];
		end else begin
			acc_sat = {accsum[ACCUM_BITS], {(ACCUM_BITS-1){~accsum[ACCUM_BITS]}}};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			pa_s1 <= gain_angle * tilt;
			pr_s1 <= gain_rate * rate;
			ps_s1 <= gain_sum * acc_q;
		end
		if (ctl.sum) begin
			ang_s2 <= angsum[32:5];
			sp_s2  <= ps_s1[ACCUM_BITS+15:8];
		end
		if (ctl.sat) begin
			out_s3 <= tot_sat;
		end
		if (ctl.acc) begin
			mixp_s4 <= mix * out_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
		end else if (ctl.acc && ctl.commit) begin
			acc_q <= acc_sat;
		end
	end

	assign axis_out = out_s3;
	assign mix_prod = mixp_s4;
endmodule

// File: rtl/core/bfa_merge.sv
// Merge stage: mixes the two lane outputs into three wheel drives, clamps,
// scales to inverted PWM duty and holds the wheel commands. Uses bfa_pkg.
module bfa_merge #(
	parameter int MAX_DUTY   = bfa_pkg::BFA_MAX_DUTY,
	parameter int ACCUM_BITS = bfa_pkg::BFA_ACCUM_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bfa_pkg::merge_ctl_t           ctl,
	input  logic [14:0]                   limit_drive,
	input  logic signed [ACCUM_BITS-1:0]  out_x,
	input  logic signed [ACCUM_BITS+15:0] mix_prod_x,
	input  logic signed [ACCUM_BITS+15:0] mix_prod_y,
	output bfa_pkg::wheel_cmd_t [bfa_pkg::WHEELS-1:0] wheels
);
	localparam int DW        = ACCUM_BITS + 4;
	localparam int DUTY_BITS = $clog2(MAX_DUTY + 1);
	localparam int PW        = 15 + DUTY_BITS;
	localparam int DUTY_WIDE = (DUTY_BITS > bfa_pkg::DUTY_FIELD_BITS) ?
		DUTY_BITS : bfa_pkg::DUTY_FIELD_BITS;
	localparam int NW        = bfa_pkg::WHEELS;

	logic signed [ACCUM_BITS+1:0] mx, my;
	logic signed [DW-1:0]         ex, ey, eo, lim;

	logic signed [DW-1:0] drv_s5  [NW];
	logic [14:0]          mag_s6  [NW];
	logic                 pos_s6  [NW];
	logic [PW-1:0]        prod_s7 [NW];

	logic [DUTY_BITS-1:0] held_duty_q [NW];
	logic                 held_dir_q  [NW];

	logic signed [DW-1:0] clamped [NW];
	logic signed [DW-1:0] magw    [NW];
	logic [DUTY_BITS:0]   pwm     [NW];
	logic [DUTY_BITS:0]   pwm_c   [NW];
	logic [DUTY_BITS-1:0] duty_n  [NW];
	logic [DUTY_WIDE-1:0] dwide   [NW];

	assign mx  = mix_prod_x[ACCUM_BITS+15:14];
	assign my  = mix_prod_y[ACCUM_BITS+15:14];
	assign ex  = DW'(mx);
	assign ey  = DW'(my);
	assign eo  = DW'(out_x);
	assign lim = DW'(limit_drive);

	always_comb begin
		for (int i = 0; i < NW; i++) begin
			if (drv_s5[i] > lim) begin
				clamped[i] = lim;
			end else if (drv_s5[i] < -lim) begin
				clamped[i] = -lim;
			end else begin
				clamped[i] = drv_s5[i];
			end
			magw[i]  = clamped[i][DW-1] ? -clamped[i] : clamped[i];
			pwm[i]   = prod_s7[i][PW-1:14];
			pwm_c[i] = (pwm[i] > (DUTY_BITS+1)'(MAX_DUTY)) ?
				(DUTY_BITS+1)'(MAX_DUTY) : pwm[i];
			duty_n[i] = DUTY_BITS'(MAX_DUTY) - pwm_c[i][DUTY_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mix) begin
			// single-axis mode drives wheel C straight from the X output
			drv_s5[bfa_pkg::WHEEL_C] <= ctl.single ? eo : (ex <<< 1);
			drv_s5[bfa_pkg::WHEEL_L] <= -ex - ey;
			drv_s5[bfa_pkg::WHEEL_R] <= ey - ex;
		end
		for (int i = 0; i < NW; i++) begin
			if (ctl.clamp) begin
				mag_s6[i] <= magw[i][14:0];
				pos_s6[i] <= (clamped[i] > 0);
			end
			if (ctl.scale) begin
				prod_s7[i] <= PW'(mag_s6[i]) * PW'(MAX_DUTY);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NW; i++) begin
				held_duty_q[i] <= DUTY_BITS'(MAX_DUTY);
				held_dir_q[i]  <= 1'b0;
			end
		end else if (ctl.duty) begin
			for (int i = 0; i < NW; i++) begin
				if (i == bfa_pkg::WHEEL_C || !ctl.single) begin
					held_duty_q[i] <= duty_n[i];
					held_dir_q[i]  <= pos_s6[i];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NW; i++) begin
			dwide[i]          = DUTY_WIDE'(held_duty_q[i]);
			wheels[i].duty    = dwide[i][bfa_pkg::DUTY_FIELD_BITS-1:0];
			wheels[i].forward = held_dir_q[i];
		end
	end
endmodule

// File: rtl/core/balance_feedback_with_arming.sv
// Top level of the balance feedback controller with arming and brake control.
// Depends on bfa_pkg, bfa_stream_if, bfa_lane and bfa_merge.
//
// Usage:
//  - sensor (sink): one request per control tick: kind, tilt_x/y, rate_x/y.
//  - command (source): one result per request: three wheel duties and
//    directions, brake_free, armed and the event code.
//  - cfg_wr_en/cfg_index/cfg_data: register writes, taken at any clock edge
//    with cfg_wr_en high; write only while no request is in flight.
// Sequencing:
//  - A request that runs the control law steps through EVAL, the shared
//    steps (multiply, sum, saturate, accumulate, mix, clamp, scale, duty),
//    one per cycle, and FIN before command.valid; an idle or disarming tick
//    goes from EVAL straight to FIN. A new request is taken only after the
//    last one has loaded its result into the output register.
//  - The X and Y lanes work side by side; the merge stage builds the wheels.
// Reset: disarmed, brakes engaged, accumulators zero, duties at MAX_DUTY,
//  directions 0, registers at their reset values.
// Stall: a result waits in the output register while command.ready is low;
//  the next request is accepted meanwhile but is held at its last step.
module balance_feedback_with_arming #(
	parameter int MAX_DUTY   = bfa_pkg::BFA_MAX_DUTY,
	parameter int ACCUM_BITS = bfa_pkg::BFA_ACCUM_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [bfa_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [bfa_pkg::CFG_DATA_BITS-1:0] cfg_data,
	bfa_stream_if.sink                        sensor,
	bfa_stream_if.source                      command
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_EVAL, ST_MUL, ST_SUM, ST_SAT, ST_ACC,
		ST_MIX, ST_CLAMP, ST_SCALE, ST_DUTY, ST_FIN
	} state_t;

	state_t st_q;

	// configuration registers
	logic signed [15:0] gain_angle_q, gain_rate_q, gain_sum_q, mix_x_q, mix_y_q;
	logic [14:0]        arm_angle_q, trip_angle_q, limit_drive_q;

	// control state
	bfa_pkg::in_item_t  item_q;
	logic               active_q, brake_q;
	logic [1:0]         event_q;
	logic               out_valid_q;
	bfa_pkg::out_item_t out_q;
	logic               res_load;

	// tick evaluation on the captured request
	logic signed [16:0] tx17, ty17;
	logic [16:0]        abs_x, abs_y;
	logic               below_start, in_limit, arm, act1, run, disarm;

	bfa_pkg::lane_ctl_t  ctl_x, ctl_y;
	bfa_pkg::merge_ctl_t mctl;

	logic signed [ACCUM_BITS-1:0]  out_x, out_y;
	logic signed [ACCUM_BITS+15:0] mixp_x, mixp_y;
	bfa_pkg::wheel_cmd_t [bfa_pkg::WHEELS-1:0] wheels;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_angle_q  <= '0;
			gain_rate_q   <= '0;
			gain_sum_q    <= '0;
			arm_angle_q   <= '0;
			trip_angle_q  <= '0;
			limit_drive_q <= 15'd16384;
			mix_x_q       <= 16'sd16384;
			mix_y_q       <= 16'sd16384;
		end else if (cfg_wr_en) begin
			unique case (bfa_pkg::cfg_reg_t'(cfg_index))
				bfa_pkg::REG_GAIN_ANGLE:  gain_angle_q  <= cfg_data;
				bfa_pkg::REG_GAIN_RATE:   gain_rate_q   <= cfg_data;
				bfa_pkg::REG_GAIN_SUM:    gain_sum_q    <= cfg_data;
				bfa_pkg::REG_START_ANGLE: arm_angle_q   <= cfg_data[14:0];
				bfa_pkg::REG_LIMIT_ANGLE: trip_angle_q  <= cfg_data[14:0];
				bfa_pkg::REG_LIMIT_DRIVE: limit_drive_q <= cfg_data[14:0];
				bfa_pkg::REG_MIX_X:       mix_x_q       <= cfg_data;
				bfa_pkg::REG_MIX_Y:       mix_y_q       <= cfg_data;
			endcase
		end
	end

	// Arm/disarm decision. Y is not watched in single-axis mode.
	assign tx17  = 17'(item_q.tilt_x);
	assign ty17  = 17'(item_q.tilt_y);
	assign abs_x = tx17[16] ? -tx17 : tx17;
	assign abs_y = ty17[16] ? -ty17 : ty17;

	assign below_start = (abs_x < 17'(arm_angle_q)) &&
		(item_q.kind || (abs_y < 17'(arm_angle_q)));
	assign in_limit    = (abs_x < 17'(trip_angle_q)) &&
		(item_q.kind || (abs_y < 17'(trip_angle_q)));
	assign arm    = !active_q && below_start;
	assign act1   = active_q || arm;
	assign run    = act1 && in_limit;
	assign disarm = act1 && !in_limit;

	// step strobes; Y lane holds its accumulator in single-axis mode, except for the clear on disarm
	always_comb begin
		ctl_x.mul    = (st_q == ST_MUL);
		ctl_x.sum    = (st_q == ST_SUM);
		ctl_x.sat    = (st_q == ST_SAT);
		ctl_x.acc    = (st_q == ST_ACC);
		ctl_x.commit = 1'b1;
		ctl_x.clear  = (st_q == ST_EVAL) && disarm;
		ctl_y        = ctl_x;
		ctl_y.commit = !item_q.kind;
		mctl.mix     = (st_q == ST_MIX);
		mctl.clamp   = (st_q == ST_CLAMP);
		mctl.scale   = (st_q == ST_SCALE);
		mctl.duty    = (st_q == ST_DUTY);
		mctl.single  = item_q.kind;
	end

	// result register takes the new command once it is free or being drained
	assign res_load = (st_q == ST_FIN) && (!out_valid_q || command.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			item_q      <= '0;
			active_q    <= 1'b0;
			brake_q     <= 1'b0;
			event_q     <= bfa_pkg::EV_NONE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (command.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (sensor.valid) begin
						item_q <= sensor.data;
						st_q   <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					active_q <= run;
					// arming releases, disarming engages; both in one tick ends engaged
					brake_q  <= (brake_q || arm) && !disarm;
					if (disarm) begin
						event_q <= arm ? bfa_pkg::EV_BOTH : bfa_pkg::EV_DISARM;
					end else begin
						event_q <= arm ? bfa_pkg::EV_ARM : bfa_pkg::EV_NONE;
					end
					st_q <= run ? ST_MUL : ST_FIN;
				end
				ST_MUL:   st_q <= ST_SUM;
				ST_SUM:   st_q <= ST_SAT;
				ST_SAT:   st_q <= ST_ACC;
				ST_ACC:   st_q <= ST_MIX;
				ST_MIX:   st_q <= ST_CLAMP;
				ST_CLAMP: st_q <= ST_SCALE;
				ST_SCALE: st_q <= ST_DUTY;
				ST_DUTY:  st_q <= ST_FIN;
				ST_FIN: begin
					// load the result once the output register is free
					if (res_load) begin
						out_q.duty_c     <= wheels[bfa_pkg::WHEEL_C].duty;
						out_q.forward_c  <= wheels[bfa_pkg::WHEEL_C].forward;
						out_q.duty_l     <= wheels[bfa_pkg::WHEEL_L].duty;
						out_q.forward_l  <= wheels[bfa_pkg::WHEEL_L].forward;
						out_q.duty_r     <= wheels[bfa_pkg::WHEEL_R].duty;
						out_q.forward_r  <= wheels[bfa_pkg::WHEEL_R].forward;
						out_q.brake_free <= brake_q;
						out_q.armed      <= active_q;
						out_q.event_res  <= event_q;
						st_q             <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign sensor.ready  = (st_q == ST_IDLE);
	assign command.valid = out_valid_q;
	assign command.data  = out_q;

	bfa_lane #(.ACCUM_BITS(ACCUM_BITS)) u_lane_x (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl_x),
		.tilt       (item_q.tilt_x),
		.rate       (item_q.rate_x),
		.gain_angle (gain_angle_q),
		.gain_rate  (gain_rate_q),
		.gain_sum   (gain_sum_q),
		.mix        (mix_x_q),
		.axis_out   (out_x),
		.mix_prod   (mixp_x)
	);

	bfa_lane #(.ACCUM_BITS(ACCUM_BITS)) u_lane_y (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl_y),
		.tilt       (item_q.tilt_y),
		.rate       (item_q.rate_y),
		.gain_angle (gain_angle_q),
		.gain_rate  (gain_rate_q),
		.gain_sum   (gain_sum_q),
		.mix        (mix_y_q),
		.axis_out   (out_y),
		.mix_prod   (mixp_y)
	);

	bfa_merge #(.MAX_DUTY(MAX_DUTY), .ACCUM_BITS(ACCUM_BITS)) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (mctl),
		.limit_drive (limit_drive_q),
		.out_x       (out_x),
		.mix_prod_x  (mixp_x),
		.mix_prod_y  (mixp_y),
		.wheels      (wheels)
	);

	// Y output only feeds the Y mix product inside its lane
	logic unused_y;
	assign unused_y = ^out_y;
endmodule

// File: rtl/core/bfa_checker.sv
// Port-level checks on the result channel of the balance feedback block.
// Depends on bfa_pkg; bound to balance_feedback_with_arming below.
module bfa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_ready,
	input bfa_pkg::out_item_t cmd_data
);
	// armed always comes with released brakes
	a_armed_brake: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_data.armed |-> cmd_data.brake_free)
		else $error("armed with brakes engaged");

	// a disarm leaves control off and brakes engaged
	a_disarm: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && (cmd_data.event_res == bfa_pkg::EV_DISARM ||
			cmd_data.event_res == bfa_pkg::EV_BOTH)
		|-> !cmd_data.armed && !cmd_data.brake_free)
		else $error("disarm event with control still active");

	// a pure arm event leaves control on
	a_arm: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_data.event_res == bfa_pkg::EV_ARM |-> cmd_data.armed)
		else $error("arm event without armed flag");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_data))
		else $error("result dropped or changed while stalled");
endmodule

bind balance_feedback_with_arming bfa_checker u_bfa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (command.valid),
	.cmd_ready (command.ready),
	.cmd_data  (command.data)
);
